// ----- rtl/core/fef_pkg.sv -----
// fef_pkg: shared constants, types and register indexes of the feedback echo filter
// used by fef_div and feedback_echo_filter_core; no dependencies
`timescale 1ns / 1ps

package fef_pkg;

   localparam int DELAY_DEPTH = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
   localparam int LEN_BITS    = 13;
   localparam int DVS_BITS    = 16;
   localparam int CHAN_BITS   = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int STEP_BITS   = $clog2(DATA_BITS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY_LENGTH     = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_FEEDBACK_DIVISOR = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_COUNT    = CSR_IDX_BITS'(2);

   localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(DELAY_DEPTH);
   localparam logic [DVS_BITS-1:0]  DVS_RESET  = DVS_BITS'(2);
   localparam logic [CHAN_BITS-1:0] CHAN_RESET = CHAN_BITS'(2);
   localparam logic [CHAN_BITS-1:0] CHAN_MONO  = CHAN_BITS'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } fef_state_type;

endpackage

// ----- rtl/core/feedback_echo_filter_core.sv -----
// feedback_echo_filter_core: stereo feedback comb echo over two delay memories
// depends on fef_pkg and fef_div
`timescale 1ns / 1ps

// After reset the block clears both 4096-entry delay memories, one entry per cycle,
// so req_ready stays low until that pass ends (configuration writes are taken
// meanwhile). Then the delay entries are read at the accepting edge, the load state
// starts the dividers, the bit-serial dividers (one per channel) produce 32 quotient
// bits and raise done, and the finish state writes back and registers the result
// once the output register is free. The block returns to idle before the next
// acceptance, so it takes no new sample before the last is written back. The result
// waits in an output register, so the next transaction is accepted while it is still
// pending. Write configuration only while no transaction is in flight.

module feedback_echo_filter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fef_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [fef_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  logic                                  req_end_of_block,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fef_pkg::DATA_BITS-1:0]  rsp_left_out,
   output logic signed [fef_pkg::DATA_BITS-1:0]  rsp_right_out,
   output logic                                  rsp_end_of_block_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fef_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [fef_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import fef_pkg::*;

   fef_state_type state_ff, state_in;

   logic [LEN_BITS-1:0]  len_ff;
   logic [DVS_BITS-1:0]  dvs_ff;
   logic [CHAN_BITS-1:0] chan_ff;

   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic [ADDR_BITS-1:0] clr_ff;

   logic signed [SAMPLE_BITS-1:0] lsmp_ff, rsmp_ff;
   logic                          eob_ff;

   logic [DATA_BITS-1:0] left_mem  [DELAY_DEPTH];
   logic [DATA_BITS-1:0] right_mem [DELAY_DEPTH];
   logic [DATA_BITS-1:0] lrd_ff, rrd_ff;

   logic                          rsp_valid_ff;
   logic signed [DATA_BITS-1:0]   lout_ff, rout_ff;
   logic                          eobo_ff;

   logic                        div_start, ldiv_done, rdiv_done;
   logic signed [DATA_BITS-1:0] lquo, rquo;

   logic                  clearing, out_free, fin_fire, stereo;
   logic                  lwr_en, rwr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [DATA_BITS-1:0]  lwr_data, rwr_data;
   logic signed [DATA_BITS:0] lsum, rsum;
   logic signed [DATA_BITS-1:0] lsat, rsat;
   logic [LEN_BITS-1:0]   len_eff;
   logic [ADDR_BITS:0]    pos_inc;

   function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [DATA_BITS:0] s);
      logic signed [DATA_BITS-1:0] r;
      if (s[DATA_BITS] != s[DATA_BITS-1]) begin
         r = s[DATA_BITS] ? {1'b1, {(DATA_BITS-1){1'b0}}} : {1'b0, {(DATA_BITS-1){1'b1}}};
      end else begin
         r = s[DATA_BITS-1:0];
      end
      return r;
   endfunction

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_RESET;
         dvs_ff  <= DVS_RESET;
         chan_ff <= CHAN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DELAY_LENGTH:     len_ff  <= csr_wdata[LEN_BITS-1:0];
            CSR_FEEDBACK_DIVISOR: dvs_ff  <= csr_wdata[DVS_BITS-1:0];
            CSR_CHANNEL_COUNT:    chan_ff <= csr_wdata[CHAN_BITS-1:0];
            default:              ;
         endcase
      end
   end

   assign stereo = (chan_ff != CHAN_MONO);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == ADDR_BITS'(DELAY_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV:    if (ldiv_done && rdiv_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      clearing  = 1'b0;
      div_start = 1'b0;
      fin_fire  = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clearing = 1'b1;
         ST_IDLE:   req_ready = 1'b1;
         ST_LOAD:   div_start = 1'b1;
         ST_DIV:    ;
         ST_FINISH: fin_fire = out_free;
         default:   ;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
         pos_ff <= pos_in;
      end
   end

   // write position advance and wrap
   always_comb begin
      priority if (len_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (len_ff > LEN_BITS'(DELAY_DEPTH)) begin
         len_eff = LEN_BITS'(DELAY_DEPTH);
      end else begin
         len_eff = len_ff;
      end
      pos_inc = {1'b0, pos_ff} + 1'b1;
      pos_in  = pos_ff;
      if (fin_fire) begin
         if (LEN_BITS'(pos_inc) >= len_eff) begin
            pos_in = '0;
         end else begin
            pos_in = pos_inc[ADDR_BITS-1:0];
         end
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         lsmp_ff <= req_left_sample;
         rsmp_ff <= req_right_sample;
         eob_ff  <= req_end_of_block;
      end
   end

   // dividers
   fef_div u_ldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ($signed(lrd_ff)),
      .divisor  (dvs_ff),
      .done     (ldiv_done),
      .quotient (lquo)
   );

   fef_div u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ($signed(rrd_ff)),
      .divisor  (dvs_ff),
      .done     (rdiv_done),
      .quotient (rquo)
   );

   always_comb begin
      lsum = {lquo[DATA_BITS-1], lquo}
           + {{(DATA_BITS+1-SAMPLE_BITS){lsmp_ff[SAMPLE_BITS-1]}}, lsmp_ff};
      rsum = {rquo[DATA_BITS-1], rquo}
           + {{(DATA_BITS+1-SAMPLE_BITS){rsmp_ff[SAMPLE_BITS-1]}}, rsmp_ff};
      lsat = sat32(lsum);
      rsat = sat32(rsum);
   end

   // delay memories: clearing pass or write-back, registered read at the write position
   assign wr_addr  = clearing ? clr_ff : pos_ff;
   assign lwr_data = clearing ? '0 : lsat;
   assign rwr_data = clearing ? '0 : rsat;
   assign lwr_en   = clearing || fin_fire;
   assign rwr_en   = clearing || (fin_fire && stereo);

   always_ff @(posedge clock) begin
      if (lwr_en) left_mem[wr_addr] <= lwr_data;
      lrd_ff <= left_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (rwr_en) right_mem[wr_addr] <= rwr_data;
      rrd_ff <= right_mem[pos_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_fire) begin
         lout_ff <= lsat;
         rout_ff <= stereo ? rsat : '0;
         eobo_ff <= eob_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_left_out         = lout_ff;
   assign rsp_right_out        = rout_ff;
   assign rsp_end_of_block_out = eobo_ff;

   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("transaction accepted during clearing pass");

   a_accept_starts_load : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_LOAD)
      else $error("accepted transaction did not start a memory read");

   a_result_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside write-back");

   a_pos_moves_on_writeback : assert property (@(posedge clock) disable iff (reset)
      !$stable(pos_ff) |-> $past(fin_fire))
      else $error("write position moved without a write-back");

   a_div_done_in_div : assert property (@(posedge clock) disable iff (reset)
      ldiv_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

endmodule

// ----- rtl/core/fef_div.sv -----
// fef_div: bit-serial signed by unsigned divider, truncating toward zero
// one quotient bit per cycle; depends on fef_pkg
`timescale 1ns / 1ps

module fef_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [fef_pkg::DATA_BITS-1:0] dividend,
   input  logic [fef_pkg::DVS_BITS-1:0]   divisor,
   output logic                           done,
   output logic signed [fef_pkg::DATA_BITS-1:0] quotient
);
   import fef_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_BITS-1:0]    cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [DATA_BITS-1:0]    quo_ff, quo_in;
   logic [DVS_BITS-1:0]     rem_ff, rem_in;
   logic [DVS_BITS-1:0]     dvs_ff, dvs_in;
   logic [DVS_BITS:0]       trial;
   logic [DVS_BITS:0]       diff;
   logic [DATA_BITS-1:0]    mag;

   always_comb begin
      mag   = dividend[DATA_BITS-1] ? (~dividend + 1'b1) : dividend;
      trial = {rem_ff, quo_ff[DATA_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[DATA_BITS-1];
         quo_in  = mag;
         rem_in  = '0;
         dvs_in  = (divisor == '0) ? DVS_BITS'(1) : divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_BITS-1:0];
            quo_in = {quo_ff[DATA_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_BITS-1:0];
            quo_in = {quo_ff[DATA_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_BITS'(DATA_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for feedback_echo_filter_core, with an echo tracker class
// that predicts every result and the tasks that drive the request and CSR channels
// depends on fef_pkg and feedback_echo_filter_core
`timescale 1ns / 1ps

module tb_top;
   import fef_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = CSR_IDX_BITS'(3);
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 1800;
   localparam int unsigned HOLD_AT      = 400;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned CALM_FROM    = 700;
   localparam int unsigned CALM_TO      = 1000;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483647 - 64'sd1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [DATA_BITS-1:0]   echo_type;

   localparam sample_type S_MAX = 16'sh7FFF;
   localparam sample_type S_MIN = 16'sh8000;

   typedef struct {
      echo_type left;
      echo_type right;
      logic     eob;
   } echo_result_type;

   class echo_tracker;
      echo_type             left_line [DELAY_DEPTH];
      echo_type             right_line [DELAY_DEPTH];
      int unsigned          tap;
      logic [LEN_BITS-1:0]  echo_len;
      logic [DVS_BITS-1:0]  divisor;
      logic [CHAN_BITS-1:0] chans;
      echo_result_type      awaited [$];
      int unsigned          mismatches;

      function new();
         foreach (left_line[i]) begin
            left_line[i]  = '0;
            right_line[i] = '0;
         end
         tap        = 0;
         echo_len   = LEN_RESET;
         divisor    = DVS_RESET;
         chans      = CHAN_RESET;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_DELAY_LENGTH:     echo_len = data[LEN_BITS-1:0];
            CSR_FEEDBACK_DIVISOR: divisor  = data[DVS_BITS-1:0];
            CSR_CHANNEL_COUNT:    chans    = data[CHAN_BITS-1:0];
            default: ;
         endcase
      endfunction

      // delayed value scaled down, new sample added, clipped to 32 bits
      function echo_type feed_back(echo_type stored, sample_type fresh);
         longint dvs;
         longint sum;
         dvs = (divisor == '0) ? 64'sd1 : longint'(divisor);
         sum = longint'(stored) / dvs + longint'(fresh);
         if (sum > SUM_MAX) sum = SUM_MAX;
         if (sum < SUM_MIN) sum = SUM_MIN;
         return echo_type'(sum);
      endfunction

      function void take_sample(sample_type l, sample_type r, logic eob);
         int unsigned     span;
         echo_result_type res;
         span = (echo_len == '0) ? 1 : ((echo_len > DELAY_DEPTH) ? DELAY_DEPTH : echo_len);
         res.left = feed_back(left_line[tap], l);
         left_line[tap] = res.left;
         res.right = '0;
         if (chans != CHAN_MONO) begin
            res.right = feed_back(right_line[tap], r);
            right_line[tap] = res.right;
         end
         res.eob = eob;
         awaited.push_back(res);
         tap = (tap + 1 >= span) ? 0 : tap + 1;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_echo(echo_type l, echo_type r, logic eob);
         echo_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected transaction left %0d right %0d", l, r));
            return;
         end
         want = awaited.pop_front();
         if (l !== want.left)
            report($sformatf("left_out %0d, expected %0d", l, want.left));
         if (r !== want.right)
            report($sformatf("right_out %0d, expected %0d", r, want.right));
         if (eob !== want.eob)
            report($sformatf("end_of_block_out %b, expected %b", eob, want.eob));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   sample_type               req_left_sample = '0;
   sample_type               req_right_sample = '0;
   logic                     req_end_of_block = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   echo_type                 rsp_left_out;
   echo_type                 rsp_right_out;
   logic                     rsp_end_of_block_out;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   echo_tracker tracker = new();
   int unsigned inputs_taken = 0;
   int unsigned results_seen = 0;
   int unsigned cycle_count;

   feedback_echo_filter_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input sample_type l, input sample_type r, input logic eob);
      @(negedge clock);
      while (!(inputs_taken >= CALM_FROM && inputs_taken < CALM_TO)
             && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= l;
      req_right_sample <= r;
      req_end_of_block <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_sample(l, r, eob);
      inputs_taken++;
   endtask

   // input idle and every expected transaction back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic setup(input logic [CSR_DATA_BITS-1:0] len, input logic [CSR_DATA_BITS-1:0] dvs,
                        input logic [CSR_DATA_BITS-1:0] chan);
      settle();
      write_reg(CSR_DELAY_LENGTH, len);
      write_reg(CSR_FEEDBACK_DIVISOR, dvs);
      write_reg(CSR_CHANNEL_COUNT, chan);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0: return S_MAX;
         1: return S_MIN;
         2, 3: return sample_type'(int'($urandom_range(16)) - 8);
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic random_phase(input int unsigned count);
      logic [CSR_DATA_BITS-1:0] len;
      logic [CSR_DATA_BITS-1:0] dvs;
      case ($urandom_range(9))
         0: len = '0;
         1: len = CSR_DATA_BITS'(DELAY_DEPTH);
         2: len = CSR_DATA_BITS'($urandom_range(DELAY_DEPTH + 1, 8191));
         3: len = CSR_DATA_BITS'($urandom_range(1, DELAY_DEPTH));
         default: len = CSR_DATA_BITS'($urandom_range(1, 12));
      endcase
      case ($urandom_range(7))
         0: dvs = '0;
         1: dvs = 16'd1;
         2: dvs = 16'hFFFF;
         3: dvs = CSR_DATA_BITS'($urandom_range(65535));
         default: dvs = CSR_DATA_BITS'($urandom_range(1, 6));
      endcase
      setup(len, dvs, CSR_DATA_BITS'($urandom_range(3)));
      repeat (count) send_sample(pick_sample(), pick_sample(), $urandom_range(9) == 0);
   endtask

   initial begin : stimulus
      int unsigned issued;
      int unsigned batch;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unused index must change nothing
      write_reg(CSR_SPARE, 16'hFFFF);
      // single entry, full feedback: samples pile up
      setup(16'd1, 16'd1, 16'd2);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(S_MAX, S_MIN, 1'b1);
      send_sample(S_MIN, S_MAX, 1'b0);
      send_sample(-16'sd1, 16'sd1, 1'b1);
      send_sample(16'sd0, 16'sd0, 1'b0);
      // zero length and zero divisor, odd channel count
      setup(16'd0, 16'd0, 16'd3);
      send_sample(S_MIN, S_MIN, 1'b1);
      send_sample(16'sd12345, -16'sd12345, 1'b0);
      // length beyond the store, largest divisor, channel count zero
      setup(16'd8191, 16'hFFFF, 16'd0);
      send_sample(S_MAX, S_MAX, 1'b0);
      send_sample(S_MIN, S_MIN, 1'b1);
      send_sample(16'sh5555, 16'shAAAA, 1'b0);
      send_sample(16'shAAAA, 16'sh5555, 1'b0);
      send_sample(-16'sd1, -16'sd1, 1'b1);
      send_sample(16'sd1, 16'sd1, 1'b0);
      // mono, position past the shortened length, negative quotients
      setup(16'd3, 16'd3, 16'd1);
      send_sample(-16'sd7, S_MAX, 1'b0);
      send_sample(S_MIN, -16'sd1, 1'b1);
      send_sample(16'sd5, 16'sd5, 1'b0);
      send_sample(-16'sd1, -16'sd1, 1'b0);
      send_sample(-16'sd4, 16'sd0, 1'b1);
      setup(16'd4096, 16'd2, 16'd2);
      send_sample(16'sd100, -16'sd100, 1'b0);
      send_sample(-16'sd100, 16'sd100, 1'b1);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         batch = $urandom_range(40, 110);
         random_phase(batch);
         issued += batch;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.awaited.size() != 0)
         tracker.report($sformatf("%0d transactions never came back", tracker.awaited.size()));
      if (tracker.mismatches == 0)
         $display("PASS feedback_echo_filter_core");
      else
         $display("FAIL feedback_echo_filter_core");
      $finish;
   end

   initial begin : result_side
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off so the core backs up and stalls its input
         if (!held && results_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= (results_seen >= CALM_FROM && results_seen < CALM_TO)
                      || ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_echo(rsp_left_out, rsp_right_out, rsp_end_of_block_out);
         results_seen++;
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL feedback_echo_filter_core");
      $finish;
   end

endmodule
